@@ sv/lep_pkg.sv @@
package lep_pkg;

    localparam int COORD_FRAC_BITS   = 16;
    localparam int MAX_LANES_PER_DIR = 16;
    localparam int DIR_FRAC_BITS     = 30;
    localparam int ROOT_W            = 32;
    localparam int QUOT_W            = DIR_FRAC_BITS + 1;
    localparam int LATMAG_W          = 38;
    localparam int LATHALF_W         = LATMAG_W / 2;

    typedef struct packed {
        logic                    from_src;
        logic signed [31:0]      sx;
        logic signed [31:0]      sy;
        logic signed [31:0]      ex;
        logic signed [31:0]      ey;
        logic                    off_neg;
        logic [31:0]             off_mag;
        logic                    xneg;
        logic                    yneg;
        logic                    k2neg;
        logic [6:0]              k2abs;
        logic [LATMAG_W-1:0]     lat_mag;
    } t_carry;

endpackage

@@ sv/lane_endpoint_position.sv @@
// Lane endpoint position unit. Takes one lane query per clock (busy is high only in reset) and
// returns its point at the end of the pipeline, flagged by o_valid for one cycle; the
// receiver cannot stall, so every result must be taken when it appears. The pipeline holds
// the 32-stage square root giving the road length and the 31-stage divider that normalizes
// the direction, plus four entry stages and four multiply/add/clamp stages. lane_width is
// written through the cfg channel (always ready) and must only change with no item in flight.
module lane_endpoint_position #(
    parameter int COORD_FRAC_BITS   = lep_pkg::COORD_FRAC_BITS,
    parameter int MAX_LANES_PER_DIR = lep_pkg::MAX_LANES_PER_DIR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    input  logic signed [31:0] i_offset,
    input  logic [3:0]         i_lane_index,
    input  logic               i_is_forward,
    input  logic [4:0]         i_num_forward,
    input  logic [4:0]         i_num_backward,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_lane_width,
    output logic               o_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic               o_zero_length,
    output logic               o_saturated
);

    localparam int ROOT_W = lep_pkg::ROOT_W;
    localparam int QUOT_W = lep_pkg::QUOT_W;
    localparam int DFB    = lep_pkg::DIR_FRAC_BITS;
    localparam int LMW    = lep_pkg::LATMAG_W;
    localparam int LHW    = lep_pkg::LATHALF_W;
    localparam int LAT    = 4 + ROOT_W + QUOT_W + 4;
    localparam logic [30:0] LW_RST = 31'(7 << (COORD_FRAC_BITS - 1));

    logic [30:0] r_lane_width;
    logic [LAT-1:0] r_vld;

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_width <= LW_RST;
            r_vld        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_lane_width <= i_cfg_lane_width;
            end
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // entry: differences, lane slot
    logic [4:0]         nf_c, nb_c;
    logic signed [7:0]  idx, k2;
    lep_pkg::t_carry    n_a_c;

    always_comb begin
        nf_c = (int'(i_num_forward) > MAX_LANES_PER_DIR) ? 5'(MAX_LANES_PER_DIR) : i_num_forward;
        nb_c = (int'(i_num_backward) > MAX_LANES_PER_DIR) ? 5'(MAX_LANES_PER_DIR)
                                                           : i_num_backward;
        if (i_is_forward) begin
            idx = $signed({4'b0, i_lane_index}) + $signed({3'b0, nb_c});
        end else begin
            idx = $signed({3'b0, nb_c}) - 8'sd1 - $signed({4'b0, i_lane_index});
        end
        k2 = (idx <<< 1) - $signed({3'b0, nf_c}) - $signed({3'b0, nb_c}) + 8'sd1;
        n_a_c.from_src = i_req_type ^ i_is_forward;
        n_a_c.sx       = i_src_x;
        n_a_c.sy       = i_src_y;
        n_a_c.ex       = i_dst_x;
        n_a_c.ey       = i_dst_y;
        n_a_c.off_neg  = i_offset[31];
        n_a_c.off_mag  = i_offset[31] ? 32'(-i_offset) : 32'(i_offset);
        n_a_c.xneg     = 1'b0;
        n_a_c.yneg     = 1'b0;
        n_a_c.k2neg    = k2[7];
        n_a_c.k2abs    = k2[7] ? 7'(-k2) : k2[6:0];
        n_a_c.lat_mag  = '0;
    end

    logic signed [32:0] r_a_dx, r_a_dy;
    lep_pkg::t_carry    r_a_c;

    always_ff @(posedge i_clk) begin
        r_a_dx       <= $signed({i_dst_x[31], i_dst_x}) - $signed({i_src_x[31], i_src_x});
        r_a_dy       <= $signed({i_dst_y[31], i_dst_y}) - $signed({i_src_y[31], i_src_y});
        r_a_c        <= n_a_c;
    end

    // stage B: magnitudes, range halving, lateral magnitude
    logic [32:0]     abs_x, abs_y;
    logic            halve;
    lep_pkg::t_carry n_b_c;
    logic [30:0]     r_b_ax, r_b_ay;
    lep_pkg::t_carry r_b_c;

    always_comb begin
        abs_x = r_a_dx[32] ? 33'(-r_a_dx) : 33'(r_a_dx);
        abs_y = r_a_dy[32] ? 33'(-r_a_dy) : 33'(r_a_dy);
        halve = abs_x[32] | abs_x[31] | abs_y[32] | abs_y[31];
        n_b_c         = r_a_c;
        n_b_c.xneg    = r_a_dx[32];
        n_b_c.yneg    = r_a_dy[32];
        n_b_c.lat_mag = {7'b0, r_lane_width} * {31'b0, r_a_c.k2abs};
    end

    always_ff @(posedge i_clk) begin
        r_b_ax <= halve ? abs_x[31:1] : abs_x[30:0];
        r_b_ay <= halve ? abs_y[31:1] : abs_y[30:0];
        r_b_c  <= n_b_c;
    end

    // stage C: squares, stage D: sum
    logic [61:0]     r_c_sqx, r_c_sqy;
    logic [30:0]     r_c_ax, r_c_ay, r_d_ax, r_d_ay;
    lep_pkg::t_carry r_c_c, r_d_c;
    logic [62:0]     r_d_rad;

    always_ff @(posedge i_clk) begin
        r_c_sqx <= {31'b0, r_b_ax} * {31'b0, r_b_ax};
        r_c_sqy <= {31'b0, r_b_ay} * {31'b0, r_b_ay};
        r_c_ax  <= r_b_ax;
        r_c_ay  <= r_b_ay;
        r_c_c   <= r_b_c;
        r_d_rad <= {1'b0, r_c_sqx} + {1'b0, r_c_sqy};
        r_d_ax  <= r_c_ax;
        r_d_ay  <= r_c_ay;
        r_d_c   <= r_c_c;
    end

    // square root, one root bit per stage
    logic [63:0]       r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic [30:0]       r_sq_ax   [ROOT_W];
    logic [30:0]       r_sq_ay   [ROOT_W];
    lep_pkg::t_carry   r_sq_c    [ROOT_W];
    logic [63:0]       n_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_sq_root [ROOT_W];

    always_comb begin
        logic [63:0]       rem_in, trial;
        logic [ROOT_W-1:0] root_in;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rem_in  = {1'b0, r_d_rad};
                root_in = '0;
            end else begin
                rem_in  = r_sq_rem[k-1];
                root_in = r_sq_root[k-1];
            end
            trial = (64'(root_in) << (ROOT_W - k)) | (64'd1 << (2 * (ROOT_W - 1 - k)));
            if (rem_in >= trial) begin
                n_sq_rem[k]  = rem_in - trial;
                n_sq_root[k] = root_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end else begin
                n_sq_rem[k]  = rem_in;
                n_sq_root[k] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem  <= n_sq_rem;
        r_sq_root <= n_sq_root;
        r_sq_ax[0] <= r_d_ax;
        r_sq_ay[0] <= r_d_ay;
        r_sq_c[0]  <= r_d_c;
        for (int k = 1; k < ROOT_W; k++) begin
            r_sq_ax[k] <= r_sq_ax[k-1];
            r_sq_ay[k] <= r_sq_ay[k-1];
            r_sq_c[k]  <= r_sq_c[k-1];
        end
    end

    // direction divide, one quotient bit per stage for both components
    logic [32:0]       r_dv_rx  [QUOT_W];
    logic [32:0]       r_dv_ry  [QUOT_W];
    logic [QUOT_W-1:0] r_dv_qx  [QUOT_W];
    logic [QUOT_W-1:0] r_dv_qy  [QUOT_W];
    logic [ROOT_W-1:0] r_dv_len [QUOT_W];
    lep_pkg::t_carry   r_dv_c   [QUOT_W];
    logic [32:0]       n_dv_rx  [QUOT_W];
    logic [32:0]       n_dv_ry  [QUOT_W];
    logic [QUOT_W-1:0] n_dv_qx  [QUOT_W];
    logic [QUOT_W-1:0] n_dv_qy  [QUOT_W];

    always_comb begin
        logic [32:0]       rx, ry, lx, sx_r, sy_r;
        logic [QUOT_W-1:0] qx, qy;
        logic              gx, gy;
        for (int j = 0; j < QUOT_W; j++) begin
            if (j == 0) begin
                rx = {2'b0, r_sq_ax[ROOT_W-1]};
                ry = {2'b0, r_sq_ay[ROOT_W-1]};
                qx = '0;
                qy = '0;
                lx = {1'b0, r_sq_root[ROOT_W-1]};
            end else begin
                rx = r_dv_rx[j-1];
                ry = r_dv_ry[j-1];
                qx = r_dv_qx[j-1];
                qy = r_dv_qy[j-1];
                lx = {1'b0, r_dv_len[j-1]};
            end
            gx   = rx >= lx;
            gy   = ry >= lx;
            sx_r = gx ? rx - lx : rx;
            sy_r = gy ? ry - lx : ry;
            n_dv_rx[j] = {sx_r[31:0], 1'b0};
            n_dv_ry[j] = {sy_r[31:0], 1'b0};
            n_dv_qx[j] = qx | (QUOT_W'(gx) << (QUOT_W - 1 - j));
            n_dv_qy[j] = qy | (QUOT_W'(gy) << (QUOT_W - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rx <= n_dv_rx;
        r_dv_ry <= n_dv_ry;
        r_dv_qx <= n_dv_qx;
        r_dv_qy <= n_dv_qy;
        r_dv_len[0] <= r_sq_root[ROOT_W-1];
        r_dv_c[0]   <= r_sq_c[ROOT_W-1];
        for (int j = 1; j < QUOT_W; j++) begin
            r_dv_len[j] <= r_dv_len[j-1];
            r_dv_c[j]   <= r_dv_c[j-1];
        end
    end

    // M1: products
    logic              zero_len;
    logic [QUOT_W-1:0] ux, uy;
    lep_pkg::t_carry   dc;
    logic [62:0]       r_m1_ax, r_m1_ay;
    logic [49:0]       r_m1_lxl, r_m1_lxh, r_m1_lyl, r_m1_lyh;
    logic              r_m1_zero;
    lep_pkg::t_carry   r_m1_c;

    assign dc       = r_dv_c[QUOT_W-1];
    assign zero_len = (r_dv_len[QUOT_W-1] == '0);
    assign ux       = zero_len ? '0 : r_dv_qx[QUOT_W-1];
    assign uy       = zero_len ? '0 : r_dv_qy[QUOT_W-1];

    always_ff @(posedge i_clk) begin
        r_m1_ax   <= 63'(dc.off_mag) * 63'(ux);
        r_m1_ay   <= 63'(dc.off_mag) * 63'(uy);
        r_m1_lxl  <= 50'(dc.lat_mag[LHW-1:0]) * 50'(uy);
        r_m1_lxh  <= 50'(dc.lat_mag[LMW-1:LHW]) * 50'(uy);
        r_m1_lyl  <= 50'(dc.lat_mag[LHW-1:0]) * 50'(ux);
        r_m1_lyh  <= 50'(dc.lat_mag[LMW-1:LHW]) * 50'(ux);
        r_m1_zero <= zero_len;
        r_m1_c    <= dc;
    end

    // M2: rounding, signs, base node
    logic [33:0]        al_mx, al_my;
    logic [69:0]        lat_fx, lat_fy;
    logic [38:0]        lat_mx, lat_my;
    logic               al_nx, al_ny, lt_nx, lt_ny;
    logic signed [34:0] r_m2_alx, r_m2_aly;
    logic signed [39:0] r_m2_ltx, r_m2_lty;
    logic signed [31:0] r_m2_bx, r_m2_by;
    logic               r_m2_zero;

    always_comb begin
        al_mx  = 34'((r_m1_ax + (63'd1 << (DFB - 1))) >> DFB);
        al_my  = 34'((r_m1_ay + (63'd1 << (DFB - 1))) >> DFB);
        lat_fx = (70'(r_m1_lxh) << LHW) + 70'(r_m1_lxl) + (70'd1 << DFB);
        lat_fy = (70'(r_m1_lyh) << LHW) + 70'(r_m1_lyl) + (70'd1 << DFB);
        lat_mx = 39'(lat_fx >> (DFB + 1));
        lat_my = 39'(lat_fy >> (DFB + 1));
        al_nx  = (r_m1_c.off_neg ^ r_m1_c.xneg) ^ ~r_m1_c.from_src;
        al_ny  = (r_m1_c.off_neg ^ r_m1_c.yneg) ^ ~r_m1_c.from_src;
        lt_nx  = r_m1_c.k2neg ^ ~r_m1_c.yneg;
        lt_ny  = r_m1_c.k2neg ^ r_m1_c.xneg;
    end

    always_ff @(posedge i_clk) begin
        r_m2_alx  <= al_nx ? -$signed({1'b0, al_mx}) : $signed({1'b0, al_mx});
        r_m2_aly  <= al_ny ? -$signed({1'b0, al_my}) : $signed({1'b0, al_my});
        r_m2_ltx  <= lt_nx ? -$signed({1'b0, lat_mx}) : $signed({1'b0, lat_mx});
        r_m2_lty  <= lt_ny ? -$signed({1'b0, lat_my}) : $signed({1'b0, lat_my});
        r_m2_bx   <= r_m1_c.from_src ? r_m1_c.sx : r_m1_c.ex;
        r_m2_by   <= r_m1_c.from_src ? r_m1_c.sy : r_m1_c.ey;
        r_m2_zero <= r_m1_zero;
    end

    // M3: full-width sum
    logic signed [41:0] r_m3_px, r_m3_py;
    logic               r_m3_zero;

    always_ff @(posedge i_clk) begin
        r_m3_px   <= 42'(r_m2_bx) + 42'(r_m2_alx) + 42'(r_m2_ltx);
        r_m3_py   <= 42'(r_m2_by) + 42'(r_m2_aly) + 42'(r_m2_lty);
        r_m3_zero <= r_m2_zero;
    end

    // output: clamp
    localparam logic signed [41:0] MAXV = 42'sd2147483647;
    localparam logic signed [41:0] MINV = -42'sd2147483648;
    logic               hx, lx_s, hy, ly_s;
    logic signed [31:0] r_px, r_py;
    logic               r_zero, r_sat;

    always_comb begin
        hx   = r_m3_px > MAXV;
        lx_s = r_m3_px < MINV;
        hy   = r_m3_py > MAXV;
        ly_s = r_m3_py < MINV;
    end

    always_ff @(posedge i_clk) begin
        r_px   <= hx ? 32'sh7FFFFFFF : (lx_s ? 32'sh80000000 : r_m3_px[31:0]);
        r_py   <= hy ? 32'sh7FFFFFFF : (ly_s ? 32'sh80000000 : r_m3_py[31:0]);
        r_zero <= r_m3_zero;
        r_sat  <= hx | lx_s | hy | ly_s;
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_pos_x       = r_px;
    assign o_pos_y       = r_py;
    assign o_zero_length = r_zero;
    assign o_saturated   = r_sat;

`ifndef SYNTHESIS
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item produced no result");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without accepted item");
`endif

endmodule

@@ dv/lane_endpoint_position_tb.sv @@
`timescale 1ns / 100ps

module lane_endpoint_position_tb;

    typedef struct {
        logic              req_type;
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic signed [31:0] dst_x;
        logic signed [31:0] dst_y;
        logic signed [31:0] offset;
        logic [3:0]        lane_index;
        logic              is_forward;
        logic [4:0]        num_forward;
        logic [4:0]        num_backward;
    } t_lane_query;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic              zero_length;
        logic              saturated;
    } t_lane_point;

    localparam int          IDLE_LIMIT     = 2000;
    localparam int          SETTLE_CYCLES  = 80;
    localparam logic [30:0] WIDTH_AT_RESET = 31'd229376;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic signed [31:0] i_src_x, i_src_y, i_dst_x, i_dst_y, i_offset;
    logic [3:0]         i_lane_index;
    logic               i_is_forward;
    logic [4:0]         i_num_forward, i_num_backward;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_lane_width;
    logic               o_valid;
    logic signed [31:0] o_pos_x, o_pos_y;
    logic               o_zero_length, o_saturated;

    t_lane_point pending_points[$];
    logic [30:0] lane_width_now;
    int          error_count;
    int          queries_sent;
    int          points_checked;
    int          widths_written;
    int          idle_cycles;

    lane_endpoint_position dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_dst_x          (i_dst_x),
        .i_dst_y          (i_dst_y),
        .i_offset         (i_offset),
        .i_lane_index     (i_lane_index),
        .i_is_forward     (i_is_forward),
        .i_num_forward    (i_num_forward),
        .i_num_backward   (i_num_backward),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_lane_width (i_cfg_lane_width),
        .o_valid          (o_valid),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_zero_length    (o_zero_length),
        .o_saturated      (o_saturated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bit_w;
        root  = 64'd0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n    = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // a times a unit component, magnitude rounded half away from zero
    function automatic longint scale_by_unit(input longint a, input logic [63:0] unit_mag,
                                             input logic unit_neg, input int shift);
        logic         neg;
        logic [127:0] prod;
        logic [127:0] mag;
        neg  = (a < 0) != unit_neg;
        mag  = (a < 0) ? 128'(-a) : 128'(a);
        prod = mag * 128'(unit_mag);
        prod = (prod + (128'd1 << (shift - 1))) >> shift;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_lane_point lane_point(input t_lane_query q, input logic [30:0] width);
        t_lane_point p;
        longint      dx, dy, base_x, base_y, idx, k2, lat2, px, py, nf, nb;
        logic [63:0] ax, ay, len, ux, uy;
        logic        from_src, sat;
        dx  = longint'(q.dst_x) - longint'(q.src_x);
        dy  = longint'(q.dst_y) - longint'(q.src_y);
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        nf  = (q.num_forward > 16) ? 16 : q.num_forward;
        nb  = (q.num_backward > 16) ? 16 : q.num_backward;
        sat = 1'b0;
        ux  = 0;
        uy  = 0;
        if ((ax | ay) >= (64'd1 << 31)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        if (len != 0) begin
            ux = (ax << 30) / len;
            uy = (ay << 30) / len;
        end
        from_src = q.req_type != q.is_forward;
        if (from_src) begin
            base_x = longint'(q.src_x) + scale_by_unit(q.offset, ux, dx < 0, 30);
            base_y = longint'(q.src_y) + scale_by_unit(q.offset, uy, dy < 0, 30);
        end else begin
            base_x = longint'(q.dst_x) - scale_by_unit(q.offset, ux, dx < 0, 30);
            base_y = longint'(q.dst_y) - scale_by_unit(q.offset, uy, dy < 0, 30);
        end
        idx  = q.is_forward ? longint'(q.lane_index) + nb : nb - 1 - longint'(q.lane_index);
        k2   = 2 * idx - (nf + nb) + 1;
        lat2 = longint'(width) * k2;
        // normal is the direction turned left: (-dir_y, dir_x)
        px = base_x + scale_by_unit(lat2, uy, !(dy < 0), 31);
        py = base_y + scale_by_unit(lat2, ux, dx < 0, 31);
        p.pos_x       = clamp_coord(px, sat);
        p.pos_y       = clamp_coord(py, sat);
        p.zero_length = (len == 0);
        p.saturated   = sat;
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lane_width_now = WIDTH_AT_RESET;
            idle_cycles    = 0;
        end else begin
            t_lane_query q;
            t_lane_point want;
            logic        active;
            active = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                lane_width_now = i_cfg_lane_width;
                widths_written++;
                active = 1'b1;
            end
            if (start && !busy) begin
                q.req_type     = i_req_type;
                q.src_x        = i_src_x;
                q.src_y        = i_src_y;
                q.dst_x        = i_dst_x;
                q.dst_y        = i_dst_y;
                q.offset       = i_offset;
                q.lane_index   = i_lane_index;
                q.is_forward   = i_is_forward;
                q.num_forward  = i_num_forward;
                q.num_backward = i_num_backward;
                pending_points.push_back(lane_point(q, lane_width_now));
                active = 1'b1;
            end
            if (o_valid) begin
                active = 1'b1;
                points_checked++;
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected point x=%h y=%h", $time, o_pos_x, o_pos_y);
                    error_count++;
                end else begin
                    want = pending_points.pop_front();
                    if (o_pos_x !== want.pos_x) begin
                        $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, o_pos_x);
                        error_count++;
                    end
                    if (o_pos_y !== want.pos_y) begin
                        $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, o_pos_y);
                        error_count++;
                    end
                    if (o_zero_length !== want.zero_length) begin
                        $display("%0t: zero_length expected %b actual %b", $time,
                                 want.zero_length, o_zero_length);
                        error_count++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, o_saturated);
                        error_count++;
                    end
                end
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired with %0d points pending", $time,
                         pending_points.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_query(input t_lane_query q);
        int gap;
        i_req_type     <= q.req_type;
        i_src_x        <= q.src_x;
        i_src_y        <= q.src_y;
        i_dst_x        <= q.dst_x;
        i_dst_y        <= q.dst_y;
        i_offset       <= q.offset;
        i_lane_index   <= q.lane_index;
        i_is_forward   <= q.is_forward;
        i_num_forward  <= q.num_forward;
        i_num_backward <= q.num_backward;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        queries_sent++;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:  gap = $urandom_range(1, 3);
            5:              gap = $urandom_range(10, 40);
            default:        gap = 0;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every pending point, then let the pipeline settle
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lane_width(input logic [30:0] width);
        drain();
        i_cfg_valid      <= 1'b1;
        i_cfg_lane_width <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic t_lane_query random_query();
        t_lane_query q;
        int          mode;
        mode     = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        q.src_x  = rand_coord(mode);
        q.src_y  = rand_coord(mode);
        q.dst_x  = rand_coord(mode);
        q.dst_y  = rand_coord(mode);
        case ($urandom_range(0, 15))
            0: begin
                q.dst_x = q.src_x;
                q.dst_y = q.src_y;
            end
            1: q.dst_x = q.src_x;
            2: q.dst_y = q.src_y;
            default: ;
        endcase
        q.offset       = $urandom_range(0, 4) == 0 ? $urandom : rand_coord(2);
        q.req_type     = 1'($urandom_range(0, 1));
        q.is_forward   = 1'($urandom_range(0, 1));
        q.lane_index   = 4'($urandom_range(0, 15));
        q.num_forward  = 5'($urandom_range(0, 7) == 0 ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 16));
        q.num_backward = 5'($urandom_range(0, 7) == 0 ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 16));
        if ($urandom_range(0, 3) != 0 && q.num_forward + q.num_backward > 0) begin
            if (q.is_forward && q.num_forward > 0)
                q.lane_index = 4'($urandom_range(0, q.num_forward > 16 ? 15
                                                                      : q.num_forward - 1));
            else if (!q.is_forward && q.num_backward > 0)
                q.lane_index = 4'($urandom_range(0, q.num_backward > 16 ? 15
                                                                       : q.num_backward - 1));
        end
        return q;
    endfunction

    task automatic test_directed_cases;
        t_lane_query q;
        for (int i = 0; i < 24; i++) begin
            q              = random_query();
            q.src_x        = 0;
            q.src_y        = 0;
            q.dst_x        = 32'sh0064_0000;
            q.dst_y        = 32'sh0032_0000;
            q.offset       = 32'sh0002_0000;
            q.req_type     = i[0];
            q.is_forward   = i[1];
            q.lane_index   = 4'd1;
            q.num_forward  = 5'd2;
            q.num_backward = 5'd2;
            case (i)
                4:  begin q.dst_x = 32'sh7FFFFFFF; q.src_x = 32'sh80000000; end
                5:  begin q.dst_y = 32'sh80000000; q.src_y = 32'sh7FFFFFFF; end
                6:  begin q.dst_x = 0; q.dst_y = 0; end
                7:  begin q.src_x = 32'sh7FFFFFFF; q.dst_x = 32'sh7FFFFFFF;
                          q.src_y = 32'sh7FFFFFFF; q.dst_y = 32'sh7FFFFFFF; end
                8:  q.offset = 32'sh7FFFFFFF;
                9:  q.offset = 32'sh80000000;
                10: begin q.num_forward = 5'd0; q.num_backward = 5'd0; end
                11: begin q.num_forward = 5'd16; q.num_backward = 5'd16;
                          q.lane_index = 4'd15; end
                12: begin q.num_forward = 5'd31; q.num_backward = 5'd31; end
                13: begin q.lane_index = 4'd15; q.num_forward = 5'd1; end
                14: begin q.dst_x = 32'sh7FFFFFFF; q.dst_y = 32'sh7FFFFFFF;
                          q.offset = 32'sh80000000; end
                15: begin q.src_x = 32'sh80000000; q.src_y = 32'sh80000000;
                          q.dst_x = 32'sh7FFFFFFF; q.dst_y = 32'sh7FFFFFFF; end
                16: begin q.dst_x = 32'sh8000_0000; q.dst_y = 0; end
                17: begin q.dst_x = 1; q.dst_y = 0; q.offset = 32'sh0000_8000; end
                18: begin q.src_x = 32'sh7FFF0000; q.dst_x = 32'sh7FFFFFFF;
                          q.src_y = 0; q.dst_y = 0; q.num_backward = 5'd16;
                          q.lane_index = 4'd15; q.is_forward = 1'b0; end
                19: begin q.dst_x = -32'sh0064_0000; q.dst_y = -32'sh0001_0000; end
                default: ;
            endcase
            send_query(q);
        end
    endtask

    task automatic test_width_extremes;
        logic [30:0] widths[3];
        widths = '{31'd0, 31'h7FFFFFFF, 31'd1};
        foreach (widths[w]) begin
            write_lane_width(widths[w]);
            repeat (60) send_query(random_query());
        end
    endtask

    task automatic test_random_queries;
        for (int phase = 0; phase < 5; phase++) begin
            write_lane_width(phase == 0 ? WIDTH_AT_RESET
                                        : 31'($urandom_range(0, 32'h0010_0000)));
            repeat (210) send_query(random_query());
            if (phase == 2) begin
                drain();
                repeat (60) send_query(random_query());
            end
        end
        write_lane_width(31'($urandom));
        repeat (60) send_query(random_query());
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_req_type       <= 1'b0;
        i_src_x          <= '0;
        i_src_y          <= '0;
        i_dst_x          <= '0;
        i_dst_y          <= '0;
        i_offset         <= '0;
        i_lane_index     <= '0;
        i_is_forward     <= 1'b0;
        i_num_forward    <= '0;
        i_num_backward   <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_lane_width <= '0;
        error_count      = 0;
        queries_sent     = 0;
        points_checked   = 0;
        widths_written   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_width_extremes();
        test_random_queries();
        drain();

        $display("Sent %0d lane queries, checked %0d points, %0d lane width writes",
                 queries_sent, points_checked, widths_written);
        $display("Covered zero-length and huge roads, all end/direction cases, odd lane counts");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
